// ===== src/ctm_pkg.sv =====
// Shared constants and types for the cloverleaf tile mask block.
package ctm_pkg;

    localparam int COORD_BITS_DEF = 24;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int REG_BITS  = 24;  // tiling and offset registers
    localparam int SIZE_BITS = 18;  // leaf size register
    localparam int IDX_BITS  = 3;

    localparam int STAGES = 8;

    typedef enum logic [IDX_BITS-1:0] {
        REG_TILING_U  = 3'd0,
        REG_TILING_V  = 3'd1,
        REG_OFFSET_U  = 3'd2,
        REG_OFFSET_V  = 3'd3,
        REG_LEAF_SIZE = 3'd4,
        REG_STAGGERED = 3'd5
    } t_cfg_idx;

endpackage

// ===== src/cloverleaf_tile_mask.sv =====
// Cloverleaf tile mask: streaming pipeline, one coordinate pair in, one mask bit out.
//
// Usage:
//   Slave stream (i_s_*): one beat carries a texture coordinate pair in fixed point
//   with FRAC_BITS fraction bits. Master stream (o_m_*): one beat per input beat,
//   bit 0 is 1 when the point lies inside the cloverleaf of its tile.
//   Config channel (i_cfg_*): index selects tiling_u, tiling_v, offset_u, offset_v,
//   leaf_size, staggered (0..5); other indexes are dropped. Always ready. Write
//   only while the pipeline is empty.
// Pipeline: 8 register stages between an accepted input beat and its output beat
//   (input, product, scaled coordinate, lattice fraction, distances,
//   squares, sum and radius product, compare/output).
// Throughput: one beat per cycle when not stalled; each stage holds one beat and
//   the 32x32 square and product multipliers each sit in a stage of their own.
// Stall: each stage advances when it is empty or the next one advances, so bubbles
//   are squeezed out and the pipe keeps taking beats until all 8 stages are full.
//   Nothing is dropped or repeated under back pressure.
// Reset: synchronous, active low; empties the pipe and loads tiling 1.0,
//   offset 0, leaf size 1.0, plain lattice.
// Only the low 2*FRAC_BITS bits of the scaled coordinate set the result, so
//   the multipliers are sized by FRAC_BITS alone.
module cloverleaf_tile_mask
    import ctm_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    // coordinate stream
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // [COORD_BITS-1:0] coord_u, [2*COORD_BITS-1:COORD_BITS] coord_v, zero pad
    input  logic [((2*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    // mask stream
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // [0] inside_res, [7:1] zero
    output logic [7:0]                             o_m_tdata,
    // config write channel
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [IDX_BITS-1:0]                    i_cfg_addr,
    input  logic [REG_BITS-1:0]                    i_cfg_data
);

    localparam int W2    = 2 * FRAC_BITS;               // wide fraction bits
    localparam int EXT_W = (COORD_BITS > W2) ? COORD_BITS : W2;
    localparam int TX_W  = W2 + REG_BITS;
    localparam int RHS_W = SIZE_BITS + W2;
    localparam int SHW   = RHS_W + FRAC_BITS - 1;
    localparam int CMP_W = (SHW > 2 * W2) ? SHW : 2 * W2;

    localparam logic [W2-1:0] HALF = {1'b1, {(W2-1){1'b0}}};

    // ---------------- configuration registers ----------------
    logic [REG_BITS-1:0]  r_tiling_u, r_tiling_v, r_offset_u, r_offset_v;
    logic [SIZE_BITS-1:0] r_leaf_size;
    logic                 r_staggered;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tiling_u  <= REG_BITS'(1) << FRAC_BITS;
            r_tiling_v  <= REG_BITS'(1) << FRAC_BITS;
            r_offset_u  <= '0;
            r_offset_v  <= '0;
            r_leaf_size <= SIZE_BITS'(1) << FRAC_BITS;
            r_staggered <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_idx'(i_cfg_addr))
                REG_TILING_U:  r_tiling_u  <= i_cfg_data;
                REG_TILING_V:  r_tiling_v  <= i_cfg_data;
                REG_OFFSET_U:  r_offset_u  <= i_cfg_data;
                REG_OFFSET_V:  r_offset_v  <= i_cfg_data;
                REG_LEAF_SIZE: r_leaf_size <= i_cfg_data[SIZE_BITS-1:0];
                REG_STAGGERED: r_staggered <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- pipeline control ----------------
    // r_vld[k] marks stage k full; en[k] loads stage k.
    logic [STAGES:1] r_vld;
    logic [STAGES:1] en;

    always_comb begin
        en[STAGES] = !r_vld[STAGES] || i_m_tready;
        for (int k = STAGES - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_s_tready = en[1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_s_tvalid;
            end
            for (int k = 2; k <= STAGES; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- datapath ----------------
    // stage 1: coordinates, sign extended and cut to W2 bits (mod 2^W2)
    logic signed [COORD_BITS-1:0] in_u, in_v;
    logic signed [EXT_W-1:0]      cu_ext, cv_ext;
    logic [W2-1:0]                r1_cu, r1_cv;

    assign in_u   = i_s_tdata[COORD_BITS-1:0];
    assign in_v   = i_s_tdata[2*COORD_BITS-1:COORD_BITS];
    assign cu_ext = EXT_W'(in_u);
    assign cv_ext = EXT_W'(in_v);

    // stage 2: low half of coordinate times tiling
    logic [TX_W-1:0]   tu_ext, tv_ext;
    logic [2*W2-1:0]   prod_u, prod_v;
    logic [W2-1:0]     r2_pu, r2_pv;

    assign tu_ext = TX_W'(r_tiling_u);
    assign tv_ext = TX_W'(r_tiling_v);
    assign prod_u = r1_cu * tu_ext[W2-1:0];
    assign prod_v = r1_cv * tv_ext[W2-1:0];

    // stage 3: subtract offset (only its fraction part reaches the low bits)
    logic [W2-1:0] ou_low, ov_low;
    logic [W2-1:0] r3_x, r3_y;

    assign ou_low = {r_offset_u[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
    assign ov_low = {r_offset_v[FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};

    // stage 4: fraction within the lattice cell
    // plain: frac(x), frac(y); staggered: frac(x+y+1/2), frac(x-y+1/2)
    logic [W2-1:0] r4_fs, r4_ft;

    // stage 5: distances to the cell centre
    // plain:     du = fs - 1/2,           dv = ft - 1/2
    // staggered: du = (fs+ft)/2 - 1/2,    dv = (fs-ft)/2  (fs+ft is even)
    logic [W2:0]   pair_sum;
    logic [W2-1:0] a_u, dist_u, dist_v_plain, abs_diff, dist_v;
    logic [W2-1:0] r5_dx, r5_dy;

    assign pair_sum     = {1'b0, r4_fs} + {1'b0, r4_ft};
    assign a_u          = r_staggered ? pair_sum[W2:1] : r4_fs;
    assign dist_u       = a_u[W2-1] ? {1'b0, a_u[W2-2:0]} : HALF - a_u;
    assign dist_v_plain = r4_ft[W2-1] ? {1'b0, r4_ft[W2-2:0]} : HALF - r4_ft;
    assign abs_diff     = (r4_fs >= r4_ft) ? r4_fs - r4_ft : r4_ft - r4_fs;
    assign dist_v       = r_staggered ? (abs_diff >> 1) : dist_v_plain;

    // stage 6: squares and larger distance
    logic [2*W2-1:0] r6_sqx, r6_sqy;
    logic [W2-1:0]   r6_big;

    // stage 7: squared length and radius product
    logic [2*W2-1:0]  r7_lsq;
    logic [RHS_W-1:0] r7_rhs;

    // stage 8: lsq <= leaf_size/2 * big, with the fraction points aligned
    logic [CMP_W-1:0] cmp_lhs, cmp_rhs;
    logic             r8_inside;

    assign cmp_lhs = CMP_W'(r7_lsq);
    assign cmp_rhs = CMP_W'({r7_rhs, {(FRAC_BITS-1){1'b0}}});

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r1_cu <= cu_ext[W2-1:0];
            r1_cv <= cv_ext[W2-1:0];
        end
        if (en[2]) begin
            r2_pu <= prod_u[W2-1:0];
            r2_pv <= prod_v[W2-1:0];
        end
        if (en[3]) begin
            r3_x <= r2_pu - ou_low;
            r3_y <= r2_pv - ov_low;
        end
        if (en[4]) begin
            if (r_staggered) begin
                r4_fs <= r3_x + r3_y + HALF;
                r4_ft <= r3_x - r3_y + HALF;
            end else begin
                r4_fs <= r3_x;
                r4_ft <= r3_y;
            end
        end
        if (en[5]) begin
            r5_dx <= dist_u;
            r5_dy <= dist_v;
        end
        if (en[6]) begin
            r6_sqx <= r5_dx * r5_dx;
            r6_sqy <= r5_dy * r5_dy;
            r6_big <= (r5_dx > r5_dy) ? r5_dx : r5_dy;
        end
        if (en[7]) begin
            r7_lsq <= r6_sqx + r6_sqy;
            r7_rhs <= r_leaf_size * r6_big;
        end
        if (en[8]) begin
            r8_inside <= (cmp_lhs <= cmp_rhs);
        end
    end

    assign o_m_tvalid = r_vld[STAGES];
    assign o_m_tdata  = {7'd0, r8_inside};

    // ---------------- assertions ----------------
    // input side only stalls when the output beat is held back
    a_ready_only_on_stall: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready)
    ) else $error("input stalled while output stage free");

    // an output beat only appears when the stage before held one
    a_no_invented_beat: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (!r_vld[STAGES-1] && (!o_m_tvalid || i_m_tready)) |=> !o_m_tvalid
    ) else $error("output beat without a source beat");

    // a full pipe under stall accepts nothing new
    a_full_blocks: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld && !i_m_tready) |-> !o_s_tready
    ) else $error("full pipe took a beat during stall");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for the cloverleaf tile mask stream block.
`timescale 1ns / 100ps

module tb_top;
    import ctm_pkg::*;

    localparam int CB    = COORD_BITS_DEF;
    localparam int FB    = FRAC_BITS_DEF;
    localparam int WIDE  = 2 * FB;               // fraction bits of the scaled coordinate
    localparam int LIMIT = 400000;               // cycle budget for the whole run
    localparam int PHASES = 8;
    localparam int PHASE_ITEMS = 144;

    // register indexes that the block must drop
    localparam bit [IDX_BITS-1:0] IDX_SPARE_LO = 3'd6;
    localparam bit [IDX_BITS-1:0] IDX_SPARE_HI = 3'd7;

    // handy fixed point values
    localparam bit [REG_BITS-1:0] FX_ONE      = 24'h010000;
    localparam bit [REG_BITS-1:0] FX_NEG_HALF = 24'hFF8000;
    localparam bit [REG_BITS-1:0] FX_MAX      = 24'h7FFFFF;
    localparam bit [REG_BITS-1:0] FX_MIN      = 24'h800000;

    localparam longint HALF_W = longint'(1) <<< (WIDE - 1);

    // ------------------------------------------------------------------
    // DUT ports, all known from time zero
    // ------------------------------------------------------------------
    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_s_tvalid  = 1'b0;
    logic                  o_s_tready;
    logic [2*CB-1:0]       i_s_tdata   = '0;    // [23:0] coord_u, [47:24] coord_v
    logic                  o_m_tvalid;
    logic                  i_m_tready  = 1'b0;
    logic [7:0]            o_m_tdata;           // [0] inside_res, [7:1] zero
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [IDX_BITS-1:0]   i_cfg_addr  = '0;
    logic [REG_BITS-1:0]   i_cfg_data  = '0;

    cloverleaf_tile_mask dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the register file, updated as writes are accepted
    // ------------------------------------------------------------------
    bit [REG_BITS-1:0]  tile_u  = FX_ONE;
    bit [REG_BITS-1:0]  tile_v  = FX_ONE;
    bit [REG_BITS-1:0]  shift_u = '0;
    bit [REG_BITS-1:0]  shift_v = '0;
    bit [SIZE_BITS-1:0] leaf_sz = FX_ONE[SIZE_BITS-1:0];
    bit                 stagger = 1'b0;

    bit      mask_due[$];      // expected inside bits, oldest first
    int      beats_in  = 0;    // accepted coordinate beats
    int      beats_out = 0;    // accepted mask beats
    int      faults    = 0;
    int      cycles    = 0;
    bit      calm      = 1'b0; // no idling on either side while set

    // Expected mask bit for one coordinate pair under the shadow registers.
    // Everything is kept exact: scaled coords carry WIDE fraction bits,
    // squares carry 2*WIDE.
    function automatic bit leaf_mask(bit [CB-1:0] cu_raw, bit [CB-1:0] cv_raw);
        longint     cu, cv, tu, tv, ou, ov, x, y, cx, cy, a, b, du, dv;
        bit [63:0]  dx, dy, lsq, big, rhs, q, r;
        cu = $signed(cu_raw);
        cv = $signed(cv_raw);
        tu = tile_u;
        tv = tile_v;
        ou = longint'($signed(shift_u)) <<< FB;
        ov = longint'($signed(shift_v)) <<< FB;
        x  = cu * tu - ou;
        y  = cv * tv - ov;
        if (stagger) begin
            // round in the lattice turned by 45 degrees
            a  = (x + y + HALF_W) >>> WIDE;
            b  = (x - y + HALF_W) >>> WIDE;
            cx = (a + b) * HALF_W;
            cy = (a - b) * HALF_W;
        end else begin
            cx = ((x >>> WIDE) <<< WIDE) + HALF_W;
            cy = ((y >>> WIDE) <<< WIDE) + HALF_W;
        end
        du  = x - cx;
        dv  = y - cy;
        dx  = (du < 0) ? -du : du;
        dy  = (dv < 0) ? -dv : dv;
        lsq = dx * dx + dy * dy;
        big = (dx > dy) ? dx : dy;
        rhs = 64'(leaf_sz) * big;
        // lsq <= rhs/2 scaled up by FB fraction bits
        q   = lsq >> (FB - 1);
        r   = lsq & ((64'd1 << (FB - 1)) - 64'd1);
        return (q < rhs) || (q == rhs && r == 64'd0);
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Present one coordinate beat, maybe after a short gap, and log its
    // expected mask once it is taken.
    task automatic send_coord(bit [CB-1:0] cu, bit [CB-1:0] cv, bit known, bit want);
        if (!calm && $urandom_range(99) < 8) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {cv, cu};
        do @(posedge i_clk); while (!o_s_tready);
        beats_in++;
        mask_due.push_back(known ? want : leaf_mask(cu, cv));
    endtask

    // Stop feeding and wait until every mask beat is out, so the pipe is empty.
    task automatic drain_pipe();
        i_s_tvalid <= 1'b0;
        while (beats_out != beats_in) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
    endtask

    // One register write; the caller lowers i_cfg_valid after the last one.
    task automatic write_reg(bit [IDX_BITS-1:0] addr, bit [REG_BITS-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (addr)
            REG_TILING_U:  tile_u  = data;
            REG_TILING_V:  tile_v  = data;
            REG_OFFSET_U:  shift_u = data;
            REG_OFFSET_V:  shift_v = data;
            REG_LEAF_SIZE: leaf_sz = data[SIZE_BITS-1:0];
            REG_STAGGERED: stagger = data[0];
            default: ;
        endcase
    endtask

    // Register value for a random phase: extremes, the typical value, or random.
    function automatic bit [REG_BITS-1:0] pick_reg(bit [REG_BITS-1:0] lo,
                                                   bit [REG_BITS-1:0] hi,
                                                   bit [REG_BITS-1:0] typical,
                                                   bit [REG_BITS-1:0] spread);
        case ($urandom_range(7))
            0:       return lo;
            1:       return hi;
            2, 3:    return typical;
            default: return REG_BITS'($urandom) & spread;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Directed table: config rows and coordinate rows, walked in order
    // ------------------------------------------------------------------
    typedef enum bit {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind           kind;
        bit [IDX_BITS-1:0]   addr;
        bit [REG_BITS-1:0]   data;
        bit [CB-1:0]         cu;
        bit [CB-1:0]         cv;
        bit                  known;
        bit                  want;
    } t_row;

    t_row plan[$];

    task automatic add_item(bit [CB-1:0] cu, bit [CB-1:0] cv, bit known, bit want);
        t_row row;
        row = '{ROW_ITEM, '0, '0, cu, cv, known, want};
        plan.push_back(row);
    endtask

    task automatic add_cfg(bit [IDX_BITS-1:0] addr, bit [REG_BITS-1:0] data);
        t_row row;
        row = '{ROW_CFG, addr, data, '0, '0, 1'b0, 1'b0};
        plan.push_back(row);
    endtask

    // ------------------------------------------------------------------
    // Mask side: random back pressure, compare every beat in order
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_tready <= calm ? 1'b1 : ($urandom_range(99) >= 8);
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            beats_out++;
            if (mask_due.size() == 0) begin
                $error("inside_res: beat with nothing expected, actual %0d", o_m_tdata[0]);
                faults++;
            end else begin
                want = mask_due.pop_front();
                if (o_m_tdata[0] !== want) begin
                    $error("inside_res: expected %0d, actual %0d", want, o_m_tdata[0]);
                    faults++;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int            i;
        int            ph;
        int            k;
        bit [CB-1:0]   cu;
        bit [CB-1:0]   cv;

        // Reset config: tiling 1.0, offset 0, leaf 1.0, plain lattice.
        // Spare indexes first: a write that leaked into tiling would move row 1.
        add_cfg(IDX_SPARE_LO, 24'h000000);
        add_cfg(IDX_SPARE_HI, 24'h000000);
        add_item(24'h008000, 24'h018000, 1'b1, 1'b1);   // tile centre
        add_item(24'h000000, 24'h000000, 1'b1, 1'b0);   // tile corner
        add_item(FX_MAX, FX_MAX, 1'b0, 1'b0);
        add_item(FX_MIN, FX_MIN, 1'b0, 1'b0);
        add_item(FX_MAX, FX_MIN, 1'b0, 1'b0);
        add_item(24'h018000, FX_NEG_HALF, 1'b1, 1'b1);  // centre, negative v
        // zero leaf: only an exact centre is inside
        add_cfg(REG_LEAF_SIZE, 24'h000000);
        add_item(24'h008000, 24'h008000, 1'b1, 1'b1);
        add_item(24'h008001, 24'h008000, 1'b1, 1'b0);
        add_item(24'hFF7FFF, FX_NEG_HALF, 1'b1, 1'b0);
        // zero tiling: every point lands on the offset, here a tile centre
        add_cfg(REG_TILING_U, 24'h000000);
        add_cfg(REG_TILING_V, 24'h000000);
        add_cfg(REG_OFFSET_U, FX_NEG_HALF);
        add_cfg(REG_OFFSET_V, FX_NEG_HALF);
        add_item(24'h123456, 24'hFEDCBA, 1'b1, 1'b1);
        add_item(FX_MAX, FX_MIN, 1'b1, 1'b1);
        // register extremes; leaf gets junk in its upper bits
        add_cfg(REG_TILING_U, 24'hFFFFFF);
        add_cfg(REG_TILING_V, 24'hFFFFFF);
        add_cfg(REG_OFFSET_U, FX_MAX);
        add_cfg(REG_OFFSET_V, FX_MIN);
        add_cfg(REG_LEAF_SIZE, 24'hFFFFFF);
        add_item(FX_MAX, FX_MIN, 1'b0, 1'b0);
        add_item(FX_MIN, FX_MAX, 1'b0, 1'b0);
        add_item(24'h000001, 24'hFFFFFF, 1'b0, 1'b0);
        // staggered lattice with unit tiles
        add_cfg(REG_TILING_U, FX_ONE);
        add_cfg(REG_TILING_V, FX_ONE);
        add_cfg(REG_OFFSET_U, 24'h000000);
        add_cfg(REG_OFFSET_V, 24'h000000);
        add_cfg(REG_LEAF_SIZE, FX_ONE);
        add_cfg(REG_STAGGERED, 24'h000001);
        add_item(24'h000000, 24'h000000, 1'b1, 1'b1);   // lattice point
        add_item(24'h008000, 24'h008000, 1'b1, 1'b1);   // also a lattice point
        add_item(24'h008000, 24'h000000, 1'b0, 1'b0);   // on the leaf rim
        add_item(FX_MAX, FX_MAX, 1'b0, 1'b0);
        add_item(FX_MIN, FX_MAX, 1'b0, 1'b0);
        add_item(24'h004000, 24'hFFC000, 1'b0, 1'b0);
        // only bit 0 of staggered counts: back to plain, origin is a corner
        add_cfg(REG_STAGGERED, 24'hFFFFFE);
        add_item(24'h000000, 24'h000000, 1'b1, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (i = 0; i < plan.size(); i++) begin
            if (plan[i].kind == ROW_CFG) begin
                if (i == 0 || plan[i-1].kind != ROW_CFG) drain_pipe();
                write_reg(plan[i].addr, plan[i].data);
                if (i == plan.size() - 1 || plan[i+1].kind != ROW_CFG) i_cfg_valid <= 1'b0;
            end else begin
                send_coord(plan[i].cu, plan[i].cv, plan[i].known, plan[i].want);
            end
        end

        // Random phases: new settings each time, then a burst of coordinates.
        for (ph = 0; ph < PHASES; ph++) begin
            drain_pipe();
            write_reg(REG_TILING_U, pick_reg(24'h000000, 24'hFFFFFF, FX_ONE, 24'h03FFFF));
            write_reg(REG_TILING_V, pick_reg(24'h000000, 24'hFFFFFF, FX_ONE, 24'h03FFFF));
            write_reg(REG_OFFSET_U, pick_reg(FX_MIN, FX_MAX, 24'h000000, 24'hFFFFFF));
            write_reg(REG_OFFSET_V, pick_reg(FX_MIN, FX_MAX, 24'h000000, 24'hFFFFFF));
            write_reg(REG_LEAF_SIZE, pick_reg(24'h000000, 24'h03FFFF, FX_ONE, 24'h03FFFF)
                                     | (REG_BITS'($urandom) & 24'hFC0000));
            write_reg(REG_STAGGERED, {(REG_BITS-1)'($urandom), ph[0]});
            i_cfg_valid <= 1'b0;
            calm = (ph == 3);   // one whole phase runs back to back
            for (k = 0; k < PHASE_ITEMS; k++) begin
                case ($urandom_range(3))
                    0, 1: begin
                        cu = CB'($urandom);
                        cv = CB'($urandom);
                    end
                    2: begin    // near a plain tile centre
                        cu = {8'($urandom), 16'h8000} + CB'($urandom_range(1023)) - CB'(512);
                        cv = {8'($urandom), 16'h8000} + CB'($urandom_range(1023)) - CB'(512);
                    end
                    default: begin  // near a tile edge
                        cu = {8'($urandom), 16'h0000} + CB'($urandom_range(1023)) - CB'(512);
                        cv = {8'($urandom), 16'h0000} + CB'($urandom_range(1023)) - CB'(512);
                    end
                endcase
                send_coord(cu, cv, 1'b0, 1'b0);
            end
            calm = 1'b0;
        end

        drain_pipe();
        repeat (4 * STAGES) @(posedge i_clk);
        faults += mask_due.size();
        if (mask_due.size() != 0)
            $error("inside_res: %0d expected beats never arrived", mask_due.size());

        if (faults == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
